>>> rtl/core/asa_pkg.sv
// shared types and constants for the aligned stack allocator
// no dependencies; used by every file under rtl/core
`default_nettype none

package asa_pkg;

    // field widths fixed by the interface
    localparam int OFF_W  = 17;
    localparam int SIZE_W = 16;
    localparam int LG_W   = 4;
    // working width of the padding arithmetic, wide enough for head + header + pad + size
    localparam int CALC_W = 19;

    localparam logic [OFF_W-1:0] POOL_RESET = 17'h10000;

    typedef logic [CALC_W-1:0] t_calc;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_STACK_FULL = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // read and write strobes for the header stack memory
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> rtl/core/aligned_stack_allocator_top.sv
// top level of the aligned stack allocator: command sequencer, head and depth registers
// depends on asa_pkg, asa_pad_calc and asa_stack_mem
`default_nettype none

// LIFO pool allocator on byte offsets. Each command runs in a transfer cycle and an
// execute state: the transfer cycle registers the command, computes the padded payload
// offset from the current head and starts the header stack read; the execute state checks
// space, pushes or pops the stack memory and loads the result register. A new command is
// taken only once the one before has finished executing, since the stack memory read is
// registered and each command depends on the head left by the one before. A finished result
// waits in the output register while the next command is taken; the execute state
// stretches only while that register is still full. Stack entries are not cleared
// at reset and need no clearing pass, since a pop only reads pushed entries.
// pool_bytes is written through i_cfg_we/i_cfg_wdata and applies to every later space check.
module aligned_stack_allocator_top #(
    parameter int MAX_ALLOCS        = 256,
    parameter int HEADER_BYTES      = 24,
    parameter int HEADER_ALIGN_LOG2 = 3
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // configuration
    input  wire                        i_cfg_we,
    input  wire  [asa_pkg::OFF_W-1:0]  i_cfg_wdata,
    // command channel
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  [1:0]                 i_cmd,
    input  wire  [asa_pkg::SIZE_W-1:0] i_alloc_size,
    input  wire  [asa_pkg::LG_W-1:0]   i_align_log2,
    // result channel
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [1:0]                 o_status,
    output logic [asa_pkg::OFF_W-1:0]  o_payload_offset,
    output logic [asa_pkg::OFF_W-1:0]  o_head_offset
);

    localparam int DW = $clog2(MAX_ALLOCS + 1);
    localparam int AW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;

    // state
    asa_pkg::t_state             r_state, n_state;
    logic [asa_pkg::OFF_W-1:0]   r_pool_bytes;
    logic [asa_pkg::OFF_W-1:0]   r_head, n_head;
    logic [DW-1:0]               r_depth, n_depth;

    // registered command
    asa_pkg::t_cmd               r_cmd;
    logic [asa_pkg::SIZE_W-1:0]  r_size;
    asa_pkg::t_calc              r_pay;

    // result register
    logic                        r_out_valid;
    asa_pkg::t_status            r_status, n_status;
    logic [asa_pkg::OFF_W-1:0]   r_payload, n_payload;

    logic                        w_accept;
    logic                        w_commit;
    logic                        w_push;
    asa_pkg::t_calc              w_pay;
    asa_pkg::t_calc              w_end;
    logic [DW-1:0]               w_depth_m1;
    asa_pkg::t_mem_ctl           w_mem_ctl;
    logic [asa_pkg::OFF_W-1:0]   w_rdata;

    // padded payload offset from the current head
    asa_pad_calc #(
        .HEADER_BYTES      (HEADER_BYTES),
        .HEADER_ALIGN_LOG2 (HEADER_ALIGN_LOG2)
    ) u_pad (
        .i_head       (r_head),
        .i_align_log2 (i_align_log2),
        .o_pay        (w_pay)
    );

    // header stack memory
    assign w_depth_m1   = r_depth - DW'(1);
    assign w_mem_ctl.re = w_accept && (r_depth != '0);
    assign w_mem_ctl.we = w_push;

    asa_stack_mem #(
        .DEPTH (MAX_ALLOCS),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (r_head),
        .i_raddr (w_depth_m1[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = asa_pkg::S_EXEC;
                end
            end
            asa_pkg::S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = asa_pkg::S_IDLE;
                end
            end
            default: n_state = asa_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            asa_pkg::S_IDLE: o_in_ready = 1'b1;
            asa_pkg::S_EXEC: w_commit   = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                w_commit   = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // command execution; end >= head, so the end check also covers a lowered pool
    assign w_end = r_pay + asa_pkg::t_calc'(r_size);

    always_comb begin
        n_head    = r_head;
        n_depth   = r_depth;
        n_status  = asa_pkg::ST_OK;
        n_payload = '0;
        w_push    = 1'b0;
        case (r_cmd)
            asa_pkg::CMD_ALLOC: begin
                if (r_depth >= DW'(MAX_ALLOCS)) begin
                    n_status = asa_pkg::ST_STACK_FULL;
                end else if (w_end > asa_pkg::t_calc'(r_pool_bytes)) begin
                    n_status = asa_pkg::ST_NO_SPACE;
                end else begin
                    w_push    = w_commit;
                    n_depth   = r_depth + DW'(1);
                    n_head    = w_end[asa_pkg::OFF_W-1:0];
                    n_payload = r_pay[asa_pkg::OFF_W-1:0];
                end
            end
            asa_pkg::CMD_FREE: begin
                if (r_depth == '0) begin
                    n_status = asa_pkg::ST_EMPTY;
                end else begin
                    n_depth = w_depth_m1;
                    n_head  = w_rdata;
                end
            end
            asa_pkg::CMD_RESET: begin
                n_head  = '0;
                n_depth = '0;
            end
            default: begin
                n_status = asa_pkg::ST_OK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= asa_pkg::S_IDLE;
            r_pool_bytes <= asa_pkg::POOL_RESET;
            r_head       <= '0;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_pool_bytes <= i_cfg_wdata;
            end
            if (w_commit) begin
                r_head      <= n_head;
                r_depth     <= n_depth;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command capture on input transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= asa_pkg::t_cmd'(i_cmd);
            r_size <= i_alloc_size;
            r_pay  <= w_pay;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status  <= n_status;
            r_payload <= n_payload;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_payload_offset = r_payload;
    assign o_head_offset    = r_head;

endmodule

`default_nettype wire

>>> rtl/core/asa_stack_mem.sv
// header stack: single synchronous memory of saved head offsets
// one write and one registered read per cycle; uses asa_pkg
`default_nettype none

module asa_stack_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                       i_clk,
    input  wire  asa_pkg::t_mem_ctl   i_ctl,
    input  wire  [AW-1:0]             i_waddr,
    input  wire  [asa_pkg::OFF_W-1:0] i_wdata,
    input  wire  [AW-1:0]             i_raddr,
    output logic [asa_pkg::OFF_W-1:0] o_rdata
);

    logic [asa_pkg::OFF_W-1:0] r_mem [DEPTH];
    logic [asa_pkg::OFF_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/asa_pad_calc.sv
// payload offset calculation: header-align the head, add the header, payload-align
// combinational; uses asa_pkg
`default_nettype none

module asa_pad_calc #(
    parameter int HEADER_BYTES      = 24,
    parameter int HEADER_ALIGN_LOG2 = 3
) (
    input  wire  [asa_pkg::OFF_W-1:0] i_head,
    input  wire  [asa_pkg::LG_W-1:0]  i_align_log2,
    output asa_pkg::t_calc            o_pay
);

    localparam asa_pkg::t_calc HdrMask = asa_pkg::t_calc'((1 << HEADER_ALIGN_LOG2) - 1);

    asa_pkg::t_calc w_hdr;
    asa_pkg::t_calc w_pay_mask;
    asa_pkg::t_calc w_hdr_end;

    // pad head to header alignment, then reserve the header
    always_comb begin
        w_hdr      = (asa_pkg::t_calc'(i_head) + HdrMask) & ~HdrMask;
        w_hdr_end  = w_hdr + asa_pkg::t_calc'(HEADER_BYTES);
        w_pay_mask = (asa_pkg::t_calc'(1) << i_align_log2) - asa_pkg::t_calc'(1);
        o_pay      = (w_hdr_end + w_pay_mask) & ~w_pay_mask;
    end

endmodule

`default_nettype wire

>>> rtl/core/asa_checker.sv
// port-level checks for the aligned stack allocator, attached by bind
// depends on asa_pkg and aligned_stack_allocator_top
`default_nettype none

module asa_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        o_in_ready,
    input wire                        o_out_valid,
    input wire                        i_out_ready,
    input wire [1:0]                  o_status,
    input wire [asa_pkg::OFF_W-1:0]   o_payload_offset,
    input wire [asa_pkg::OFF_W-1:0]   o_head_offset
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_payload_offset) && $stable(o_head_offset))
        else $error("result changed while stalled");

    // a failed command reports a zero payload offset
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != asa_pkg::ST_OK) |-> o_payload_offset == '0)
        else $error("payload offset set on failed command");

    // payload never lies above the new head
    a_payload_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_payload_offset <= o_head_offset)
        else $error("payload offset beyond head");

    // one command in flight: no transfer on the cycle after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command taken while previous one executes");

    // a fresh result has a matching command transfer before it
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without a matching command");

endmodule

bind aligned_stack_allocator_top asa_checker u_asa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_payload_offset (o_payload_offset),
    .o_head_offset    (o_head_offset)
);

`default_nettype wire
